// File: src/afl_pkg.sv
// ---------------------------------------------------------------------------
// afl_pkg
// Shared types and constants of the API frame link: frame bytes, header
// layout and the result item carried through the output chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package afl_pkg;

  localparam int unsigned RxLen = 10;
  localparam int unsigned TxLen = 13;

  localparam logic [7:0] START_MARK   = 8'h7E;
  localparam logic [7:0] LEN_HI       = 8'h00;
  localparam logic [7:0] RX_LEN_LO    = 8'h06;
  localparam logic [7:0] TX_LEN_LO    = 8'h09;
  localparam logic [7:0] API_ID       = 8'h01;
  localparam logic [7:0] FRAME_ID     = 8'h00;
  localparam logic [7:0] RX_ADDR_HI   = 8'h21;
  localparam logic [7:0] TX_ADDR_HI   = 8'h20;
  localparam logic [7:0] PAIR_ADDR    = 8'h85;
  localparam logic [7:0] OPTIONS_BYTE = 8'h01;
  localparam logic [7:0] CS_BASE      = 8'hFF;

  localparam logic [7:0] DEST_RESET  = 8'h85;

  typedef enum logic [1:0] {
    ST_DRIVING  = 2'd0,
    ST_CHARGING = 2'd1,
    ST_PAIRING  = 2'd2,
    ST_SPARE    = 2'd3
  } afl_status_e;

  typedef enum logic {
    CFG_TX_STATUS = 1'b0,
    CFG_DEST_ADDR = 1'b1
  } afl_cfg_idx_e;

  typedef enum logic {
    KIND_TX = 1'b0,
    KIND_RX = 1'b1
  } afl_kind_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  rx_status;
    logic        newly_paired;
  } afl_item_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } afl_win_ctrl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } afl_out_ctrl_t;

endpackage

// File: src/afl_win_cell.sv
// ---------------------------------------------------------------------------
// afl_win_cell
// One byte of the receive window. Loads its clear value on a start byte and
// takes its neighbor's byte on a shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afl_win_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  afl_pkg::afl_win_ctrl_t ctrl_i,
  input  logic [7:0]             clr_val_i,
  input  logic [7:0]             nbr_i,
  output logic [7:0]             data_o
);
  import afl_pkg::*;

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.clr) begin
      data_d = clr_val_i;
    end else if (ctrl_i.shift) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// File: src/afl_out_cell.sv
// ---------------------------------------------------------------------------
// afl_out_cell
// One slot of the output chain. Holds a result item and its valid bit; loads
// a new item or takes its neighbor's slot as the chain drains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afl_out_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  afl_pkg::afl_out_ctrl_t ctrl_i,
  input  afl_pkg::afl_item_t     load_item_i,
  input  afl_pkg::afl_item_t     nbr_item_i,
  input  logic                   nbr_valid_i,
  output afl_pkg::afl_item_t     item_o,
  output logic                   valid_o
);
  import afl_pkg::*;

  afl_item_t item_q, item_d;
  logic      valid_q, valid_d;

  always_comb begin
    item_d  = item_q;
    valid_d = valid_q;
    if (ctrl_i.load) begin
      item_d  = load_item_i;
      valid_d = 1'b1;
    end else if (ctrl_i.shift) begin
      item_d  = nbr_item_i;
      valid_d = nbr_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

// File: src/api_frame_link.sv
// ---------------------------------------------------------------------------
// api_frame_link
// Receive checker and transmit framer for a 10-byte / 13-byte API frame.
// ---------------------------------------------------------------------------
// A received byte is taken every cycle: it shifts through a row of ten window
// cells and the frame check on the shifted window completes in that cycle; a
// passing frame appends one item to the output chain. A send tick loads all
// thirteen frame bytes into a row of thirteen output cells, which then drain
// one item per cycle toward out_valid_o while out_stall_i is low. A send tick
// waits until that chain is empty (the previous frame and each receive item
// queued behind it must drain first, and any output stall holds it longer);
// a received byte waits only while all thirteen output cells are full.
// Configuration writes are always ready.
`timescale 1ns / 1ps

module api_frame_link (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic [9:0] joy1_sample_i,
  input  logic [9:0] joy2_sample_i,
  input  logic [7:0] digital_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] tx_byte_o,
  output logic       last_o,
  output logic [7:0] rx_status_o,
  output logic       newly_paired_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import afl_pkg::*;

  localparam logic [3:0] TxCnt = 4'(TxLen);

  logic [1:0] tx_status_q;
  logic [7:0] dest_addr_q;
  logic       armed_q, armed_d;
  logic       paired_q, paired_d;
  logic [7:0] prev_tail_q, prev_tail_d;
  logic [3:0] cnt_q, cnt_d;

  logic          acc;
  logic          rx_acc;
  logic          tx_acc;
  logic          is_start;
  logic          rx_shift;
  logic          rx_pass;
  logic          rx_res;
  logic          out_shift;
  logic [3:0]    append_idx;
  logic [7:0]    rx_sum;
  afl_win_ctrl_t win_ctrl;
  logic [7:0]    win [RxLen];

  logic [7:0]    tx_bytes [TxLen];
  logic [7:0]    p9, p10, p11;
  logic [7:0]    tx_sum;
  afl_item_t     rx_item;
  afl_item_t     cell_item [TxLen];
  logic          cell_valid [TxLen];

  // ---- handshake ----
  assign in_stall_o  = cmd_i ? (cnt_q != '0) : (cnt_q == TxCnt);
  assign acc         = in_valid_i && !in_stall_o;
  assign rx_acc      = acc && !cmd_i;
  assign tx_acc      = acc && cmd_i;
  assign out_shift   = cell_valid[0] && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_status_q <= ST_PAIRING;
      dest_addr_q <= DEST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (afl_cfg_idx_e'(cfg_index_i))
        CFG_TX_STATUS: tx_status_q <= cfg_data_i[1:0];
        CFG_DEST_ADDR: dest_addr_q <= cfg_data_i;
        default:       tx_status_q <= tx_status_q;
      endcase
    end
  end

  // ---- receive window ----
  assign is_start      = (rx_byte_i == START_MARK);
  assign rx_shift      = rx_acc && !is_start && armed_q;
  assign win_ctrl.clr  = rx_acc && is_start;
  assign win_ctrl.shift = rx_shift;

  for (genvar k = 0; k < RxLen; k++) begin : g_win
    afl_win_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (win_ctrl),
      .clr_val_i ((k == RxLen - 1) ? START_MARK : 8'h00),
      .nbr_i     ((k == RxLen - 1) ? rx_byte_i : win[(k + 1) % RxLen]),
      .data_o    (win[k])
    );
  end

  // check on the window as it stands after this shift
  assign rx_sum  = win[4] + win[5] + win[6] + win[7] + win[8] + win[9];
  assign rx_pass = (win[1] == START_MARK) && (win[2] == LEN_HI) &&
                   (win[3] == RX_LEN_LO) && (win[4] == API_ID) &&
                   (win[5] == FRAME_ID) && (win[6] == RX_ADDR_HI) &&
                   (win[7] == PAIR_ADDR) && (win[8] == OPTIONS_BYTE) &&
                   (rx_byte_i == CS_BASE - rx_sum);
  assign rx_res  = rx_shift && rx_pass;

  always_comb begin
    armed_d  = armed_q;
    paired_d = paired_q;
    if (win_ctrl.clr) begin
      armed_d = 1'b1;
    end else if (rx_res) begin
      armed_d  = 1'b0;
      paired_d = 1'b1;
    end
  end

  assign rx_item.kind         = KIND_RX;
  assign rx_item.tx_byte      = 8'h00;
  assign rx_item.last         = 1'b1;
  assign rx_item.rx_status    = win[9];
  assign rx_item.newly_paired = !paired_q;

  // ---- transmit frame ----
  always_comb begin
    case (afl_status_e'(tx_status_q))
      ST_PAIRING: begin
        p9  = RX_ADDR_HI;
        p10 = PAIR_ADDR;
        p11 = prev_tail_q;
      end
      ST_CHARGING: begin
        p9  = 8'h00;
        p10 = 8'h00;
        p11 = 8'h00;
      end
      default: begin
        p9  = joy1_sample_i[9:2];
        p10 = joy2_sample_i[9:2];
        p11 = digital_byte_i;
      end
    endcase
  end

  assign prev_tail_d = tx_acc ? p11 : prev_tail_q;

  assign tx_sum = API_ID + FRAME_ID + TX_ADDR_HI + dest_addr_q + OPTIONS_BYTE +
                  {6'b0, tx_status_q} + p9 + p10 + p11;

  assign tx_bytes[0]  = START_MARK;
  assign tx_bytes[1]  = LEN_HI;
  assign tx_bytes[2]  = TX_LEN_LO;
  assign tx_bytes[3]  = API_ID;
  assign tx_bytes[4]  = FRAME_ID;
  assign tx_bytes[5]  = TX_ADDR_HI;
  assign tx_bytes[6]  = dest_addr_q;
  assign tx_bytes[7]  = OPTIONS_BYTE;
  assign tx_bytes[8]  = {6'b0, tx_status_q};
  assign tx_bytes[9]  = p9;
  assign tx_bytes[10] = p10;
  assign tx_bytes[11] = p11;
  assign tx_bytes[12] = CS_BASE - tx_sum;

  // ---- output chain ----
  assign append_idx = cnt_q - {3'b0, out_shift};

  for (genvar k = 0; k < TxLen; k++) begin : g_out
    afl_out_ctrl_t ctrl;
    afl_item_t     load_item;
    afl_item_t     tx_item;

    assign tx_item.kind         = KIND_TX;
    assign tx_item.tx_byte      = tx_bytes[k];
    assign tx_item.last         = (k == TxLen - 1);
    assign tx_item.rx_status    = 8'h00;
    assign tx_item.newly_paired = 1'b0;

    assign ctrl.load  = tx_acc || (rx_res && (append_idx == 4'(k)));
    assign ctrl.shift = out_shift;
    assign load_item  = tx_acc ? tx_item : rx_item;

    afl_out_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_item_i (load_item),
      .nbr_item_i  (cell_item[(k + 1) % TxLen]),
      .nbr_valid_i ((k == TxLen - 1) ? 1'b0 : cell_valid[(k + 1) % TxLen]),
      .item_o      (cell_item[k]),
      .valid_o     (cell_valid[k])
    );
  end

  always_comb begin
    cnt_d = cnt_q - {3'b0, out_shift} + {3'b0, rx_res};
    if (tx_acc) begin
      cnt_d = TxCnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      paired_q    <= 1'b0;
      prev_tail_q <= '0;
      cnt_q       <= '0;
    end else begin
      armed_q     <= armed_d;
      paired_q    <= paired_d;
      prev_tail_q <= prev_tail_d;
      cnt_q       <= cnt_d;
    end
  end

  assign out_valid_o    = cell_valid[0];
  assign kind_o         = cell_item[0].kind;
  assign tx_byte_o      = cell_item[0].tx_byte;
  assign last_o         = cell_item[0].last;
  assign rx_status_o    = cell_item[0].rx_status;
  assign newly_paired_o = cell_item[0].newly_paired;

endmodule

// File: src/afl_checker.sv
// ---------------------------------------------------------------------------
// afl_checker
// Port-level checks of the API frame link, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       kind_o,
  input logic [7:0] tx_byte_o,
  input logic       last_o,
  input logic [7:0] rx_status_o,
  input logic       newly_paired_o
);
  import afl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(tx_byte_o) && $stable(last_o) && $stable(rx_status_o) &&
      $stable(newly_paired_o))
    else $error("output item changed while stalled");

  a_rx_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o && tx_byte_o == 8'h00)
    else $error("receive item malformed");

  a_tx_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> rx_status_o == 8'h00 && !newly_paired_o)
    else $error("transmit item carries receive fields");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o && !kind_o) ##1 (out_valid_o && !kind_o)
      |-> tx_byte_o == START_MARK)
    else $error("transmit frame does not open with start mark");

endmodule

bind api_frame_link afl_checker u_afl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .tx_byte_o      (tx_byte_o),
  .last_o         (last_o),
  .rx_status_o    (rx_status_o),
  .newly_paired_o (newly_paired_o)
);
